// ===== rtl/core/bap_pkg.sv =====
`default_nettype none
package bap_pkg;

  localparam int unsigned DimW = 9;
  localparam int unsigned PixW = 8;
  localparam int unsigned CoordW = 8;
  localparam int unsigned MaxDim = 256;
  localparam int unsigned BlockSize = 8;
  localparam int unsigned RowBlocks = MaxDim / BlockSize;
  localparam int unsigned EdgeSlots = 2 * RowBlocks;
  localparam int unsigned SlotW = $clog2(EdgeSlots);
  localparam int unsigned SumW = 14;
  localparam int unsigned CntW = 7;
  localparam int unsigned AddrW = 2 * CoordW;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [PixW-1:0] EmptyFill = 8'd128;
  localparam logic [DimW-1:0] ResetDim = 9'd8;

  localparam logic [CfgIdxW-1:0] RegImageWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } op_e;

  typedef struct packed {
    logic            func;
    logic [PixW-1:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_out;
    logic            is_padding;
    logic            is_last;
    logic [DimW-1:0] padded_width;
    logic [DimW-1:0] padded_height;
  } out_word_t;

  typedef struct packed {
    op_e             op;
    logic [PixW-1:0] pixel;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/bap_front.sv =====
`default_nettype none
module bap_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire bap_pkg::in_word_t in_word_i,
  output logic                   cmd_valid_o,
  output bap_pkg::cmd_t          cmd_o,
  input  wire logic              cmd_pop_i
);

  bap_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q].op    <= in_word_i.func ? bap_pkg::OP_PULL : bap_pkg::OP_PUSH;
      mem_q[wr_ptr_q].pixel <= in_word_i.pixel_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bap_back.sv =====
`default_nettype none
module bap_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [bap_pkg::DimW-1:0]       width_i,
  input  wire logic [bap_pkg::DimW-1:0]       height_i,
  input  wire logic                           cmd_valid_i,
  input  wire bap_pkg::cmd_t                  cmd_i,
  output logic                                cmd_pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output bap_pkg::out_word_t                  out_word_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StAcc  = 3'd1;
  localparam logic [2:0] StFrd  = 3'd2;
  localparam logic [2:0] StSrd  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;

  logic [2:0] st_q, st_d;

  logic [bap_pkg::PixW-1:0]   frame_mem [2**bap_pkg::AddrW];
  logic [bap_pkg::SumW-1:0]   sum_mem   [bap_pkg::EdgeSlots];
  logic [bap_pkg::PixW-1:0]   frd_q;
  logic [bap_pkg::SumW-1:0]   srd_q;
  logic [bap_pkg::EdgeSlots-1:0] vld_q;
  logic                       sv_q;

  logic [bap_pkg::CoordW-1:0] lcol_q, ecol_q, erow_q;
  logic [bap_pkg::DimW-1:0]   lrow_q;
  logic                       done_q;
  logic [bap_pkg::SlotW-1:0]  slot_q;
  logic [bap_pkg::PixW-1:0]   pix_q;
  logic [bap_pkg::CntW-1:0]   div_q;
  logic                       last_q;
  logic [bap_pkg::SumW-1:0]   dvd_q;
  logic [bap_pkg::CntW-1:0]   rem_q;
  logic [3:0]                 step_q;

  logic                       out_valid_q;
  bap_pkg::out_word_t         out_q;

  logic [bap_pkg::DimW-1:0]   pw, ph;
  logic [bap_pkg::CoordW-1:0] r, c;
  logic [4:0]                 bx, by;
  logic [bap_pkg::DimW-1:0]   bx_end, by_end, bx0, by0;
  logic                       right_edge, edge_blk;
  logic [bap_pkg::SlotW-1:0]  slot;
  logic [3:0]                 spanx, spany;
  logic [bap_pkg::DimW-1:0]   remx, remy;
  logic [bap_pkg::DimW-1:0]   r1, c1;
  logic                       is_push, is_pull, go_push, go_pull, real_pix, last;
  logic [bap_pkg::CntW:0]     rs;
  logic                       ge;
  logic [bap_pkg::SumW-1:0]   acc_sum, dvd_last;

  assign pw = bap_pkg::DimW'((({1'b0, width_i} + 10'd7) >> 3) << 3);
  assign ph = bap_pkg::DimW'((({1'b0, height_i} + 10'd7) >> 3) << 3);

  assign is_push = cmd_valid_i && (cmd_i.op == bap_pkg::OP_PUSH);
  assign is_pull = cmd_valid_i && (cmd_i.op == bap_pkg::OP_PULL);
  assign r = is_push ? lrow_q[bap_pkg::CoordW-1:0] : erow_q;
  assign c = is_push ? lcol_q : ecol_q;
  assign bx = c[7:3];
  assign by = r[7:3];
  assign bx0 = {1'b0, bx, 3'b000};
  assign by0 = {1'b0, by, 3'b000};
  assign bx_end = bx0 + 9'd8;
  assign by_end = by0 + 9'd8;
  assign right_edge = bx_end > width_i;
  assign edge_blk = right_edge || (by_end > height_i);
  assign slot = right_edge ? {1'b0, by} : {1'b1, bx};
  assign remx = width_i - bx0;
  assign remy = height_i - by0;
  assign spanx = (bx0 >= width_i) ? 4'd0 : (remx < 9'd8) ? remx[3:0] : 4'd8;
  assign spany = (by0 >= height_i) ? 4'd0 : (remy < 9'd8) ? remy[3:0] : 4'd8;
  assign r1 = {1'b0, r} + 9'd1;
  assign c1 = {1'b0, c} + 9'd1;
  assign real_pix = ({1'b0, r} < height_i) && ({1'b0, c} < width_i);
  assign last = (c1 >= pw) && (r1 >= ph);

  assign go_push = (st_q == StIdle) && is_push;
  assign go_pull = (st_q == StIdle) && is_pull && !out_valid_q && done_q;
  assign cmd_pop_o = (st_q == StIdle) && cmd_valid_i &&
                     (is_push || !done_q || !out_valid_q);

  assign acc_sum = (sv_q ? srd_q : '0) + {6'd0, pix_q};
  assign rs = {rem_q, dvd_q[bap_pkg::SumW-1]};
  assign ge = rs >= {1'b0, div_q};
  assign dvd_last = {dvd_q[bap_pkg::SumW-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (go_push && !done_q) frame_mem[{r, c}] <= cmd_i.pixel;
    if (go_pull) frd_q <= frame_mem[{r, c}];
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StAcc) sum_mem[slot_q] <= acc_sum;
    if (st_q == StIdle) srd_q <= sum_mem[slot];
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: begin
        if (go_push && edge_blk && !done_q) st_d = StAcc;
        else if (go_pull) st_d = real_pix ? StFrd : StSrd;
      end
      StAcc: st_d = StIdle;
      StFrd: st_d = StIdle;
      StSrd: st_d = (div_q == '0) ? StIdle : StDiv;
      StDiv: if (step_q == 4'd13) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle) begin
      slot_q <= slot;
      pix_q  <= cmd_i.pixel;
      div_q  <= bap_pkg::CntW'({4'd0, spanx} * {4'd0, spany});
      last_q <= last;
      sv_q   <= vld_q[slot];
    end
    if (st_q == StSrd) begin
      dvd_q  <= sv_q ? srd_q : '0;
      rem_q  <= '0;
      step_q <= 4'd0;
    end
    if (st_q == StDiv) begin
      dvd_q  <= dvd_last;
      rem_q  <= ge ? bap_pkg::CntW'(rs - {1'b0, div_q}) : rs[bap_pkg::CntW-1:0];
      step_q <= step_q + 4'd1;
    end
    if ((st_q == StFrd) || (st_q == StSrd && div_q == '0) ||
        (st_q == StDiv && step_q == 4'd13)) begin
      out_q.is_last       <= last_q;
      out_q.padded_width  <= pw;
      out_q.padded_height <= ph;
      out_q.is_padding    <= (st_q != StFrd);
      if (st_q == StFrd) out_q.pixel_out <= frd_q;
      else if (st_q == StSrd) out_q.pixel_out <= bap_pkg::EmptyFill;
      else out_q.pixel_out <= (dvd_last > 14'd255) ? 8'd255 : dvd_last[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      lcol_q      <= '0;
      lrow_q      <= '0;
      ecol_q      <= '0;
      erow_q      <= '0;
      done_q      <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if ((st_q == StFrd) || (st_q == StSrd && div_q == '0) ||
          (st_q == StDiv && step_q == 4'd13)) out_valid_q <= 1'b1;
      if (st_q == StAcc) vld_q[slot_q] <= 1'b1;
      if (go_push && !done_q) begin
        if (c1 >= width_i) begin
          lcol_q <= '0;
          lrow_q <= r1;
          if (r1 >= height_i) done_q <= 1'b1;
        end else begin
          lcol_q <= c1[bap_pkg::CoordW-1:0];
        end
      end
      if (go_pull) begin
        if (c1 >= pw) begin
          if (r1 >= ph) begin
            lcol_q <= '0;
            lrow_q <= '0;
            ecol_q <= '0;
            erow_q <= '0;
            done_q <= 1'b0;
            vld_q  <= '0;
          end else begin
            ecol_q <= '0;
            erow_q <= r1[bap_pkg::CoordW-1:0];
          end
        end else begin
          ecol_q <= c1[bap_pkg::CoordW-1:0];
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/core/block_average_edge_padding_core.sv =====
`default_nettype none
// Pads an 8-bit image channel to multiples of 8 with per-block averages. Push words (func 0)
// load source pixels in raster order, one per cycle, into a 64K-entry frame memory while
// edge-block sums accumulate; a push into a right or bottom edge block stalls input for the
// read-modify-write of its sum. Once loading ends, each pull word (func 1) yields one
// padded pixel: a real pixel via the frame memory read port, or a padding pixel through the
// shared bit-serial divider (fill value 128 for a block with no real pixels). Pulls made
// before loading ends, and pushes made after it, are dropped. A two-entry queue in front
// absorbs input words while the back end works. Program width and height only while idle.
module block_average_edge_padding_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire bap_pkg::in_word_t               in_word_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output bap_pkg::out_word_t                   out_word_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bap_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [bap_pkg::DimW-1:0]        cfg_data_i
);

  logic [bap_pkg::DimW-1:0] width_q, height_q, width, height;
  logic                     cmd_valid, cmd_pop;
  bap_pkg::cmd_t            cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bap_pkg::ResetDim;
      height_q <= bap_pkg::ResetDim;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == bap_pkg::RegImageWidth) width_q <= cfg_data_i;
      if (cfg_index_i == bap_pkg::RegImageHeight) height_q <= cfg_data_i;
    end
  end

  assign width  = (width_q == '0) ? 9'd1 :
                  (width_q > 9'd256) ? 9'd256 : width_q;
  assign height = (height_q == '0) ? 9'd1 :
                  (height_q > 9'd256) ? 9'd256 : height_q;

  bap_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  bap_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width),
    .height_i    (height),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/bap_checker.sv =====
`default_nettype none
module bap_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire bap_pkg::out_word_t out_word_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_pw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.padded_width[2:0] == 3'd0 &&
                    out_word_o.padded_width != 9'd0)
    else $error("padded width not a multiple of eight");

  a_ph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.padded_height[2:0] == 3'd0 &&
                    out_word_o.padded_height != 9'd0)
    else $error("padded height not a multiple of eight");

endmodule

bind block_average_edge_padding_core bap_checker u_bap_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
`default_nettype wire

// ===== test/tb_block_average_edge_padding_core.sv =====
`default_nettype none
module tb_block_average_edge_padding_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bap_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned SettleCycles = 48;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = RegImageWidth;
  logic [DimW-1:0] cfg_data = '0;

  block_average_edge_padding_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow of the padding engine
  logic [PixW-1:0] frame_mem [MaxDim*MaxDim];
  logic [SumW-1:0] block_sums [EdgeSlots];
  int unsigned load_col, load_row, emit_col, emit_row;
  bit load_done;
  logic [DimW-1:0] width_reg = ResetDim;
  logic [DimW-1:0] height_reg = ResetDim;

  in_word_t pending_words[$];
  out_word_t expected_pixels[$];
  bit in_fire = 1'b0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  int unsigned pace_phase = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned pixels_seen = 0;
  int unsigned pads_seen = 0;
  int unsigned frames_done = 0;
  int unsigned words_queued = 0;

  function automatic int unsigned clamp_dim(logic [DimW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  function automatic int unsigned sum_slot(int unsigned r, int unsigned c, int unsigned w);
    if ((c / BlockSize + 1) * BlockSize > w) return (r / BlockSize) % RowBlocks;
    return RowBlocks + (c / BlockSize) % RowBlocks;
  endfunction

  function automatic int unsigned span(int unsigned start, int unsigned lim);
    if (start >= lim) return 0;
    return (lim - start < BlockSize) ? lim - start : BlockSize;
  endfunction

  function automatic void clear_frame();
    foreach (block_sums[i]) block_sums[i] = '0;
    load_col = 0;
    load_row = 0;
    emit_col = 0;
    emit_row = 0;
    load_done = 1'b0;
  endfunction

  function automatic bit pad_pixel(in_word_t w_in, output out_word_t o);
    int unsigned w, h, pw, ph, r, c, s, cnt, pix;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    pw = ((w + 7) / 8) * 8;
    ph = ((h + 7) / 8) * 8;
    o = '0;
    if (op_e'(w_in.func) == OP_PUSH) begin
      if (load_done) return 1'b0;
      r = load_row % MaxDim;
      c = load_col % MaxDim;
      frame_mem[r*MaxDim + c] = w_in.pixel_in;
      if ((c / 8 + 1) * 8 > w || (r / 8 + 1) * 8 > h) begin
        s = sum_slot(r, c, w);
        block_sums[s] = block_sums[s] + w_in.pixel_in;
      end
      if (c + 1 >= w) begin
        load_col = 0;
        load_row = (r + 1) & 9'h1ff;
        if (load_row >= h) load_done = 1'b1;
      end else begin
        load_col = (c + 1) & 8'hff;
      end
      return 1'b0;
    end
    if (!load_done) return 1'b0;
    r = emit_row % MaxDim;
    c = emit_col % MaxDim;
    if (r < h && c < w) begin
      o.pixel_out = frame_mem[r*MaxDim + c];
    end else begin
      cnt = span((c / 8) * 8, w) * span((r / 8) * 8, h);
      if (cnt == 0) begin
        pix = EmptyFill;
      end else begin
        pix = block_sums[sum_slot(r, c, w)] / cnt;
        if (pix > 255) pix = 255;
      end
      o.pixel_out = pix[PixW-1:0];
      o.is_padding = 1'b1;
    end
    o.padded_width = pw[DimW-1:0];
    o.padded_height = ph[DimW-1:0];
    if (c + 1 >= pw) begin
      if (r + 1 >= ph) begin
        o.is_last = 1'b1;
        clear_frame();
      end else begin
        emit_col = 0;
        emit_row = (r + 1) & 8'hff;
      end
    end else begin
      emit_col = (c + 1) & 8'hff;
    end
    return 1'b1;
  endfunction

  task automatic check_pixel(out_word_t exp, out_word_t got);
    if (got.pixel_out !== exp.pixel_out) begin
      $error("pixel_out: expected %0d, got %0d", exp.pixel_out, got.pixel_out);
      errors++;
    end
    if (got.is_padding !== exp.is_padding) begin
      $error("is_padding: expected %0d, got %0d", exp.is_padding, got.is_padding);
      errors++;
    end
    if (got.is_last !== exp.is_last) begin
      $error("is_last: expected %0d, got %0d", exp.is_last, got.is_last);
      errors++;
    end
    if (got.padded_width !== exp.padded_width) begin
      $error("padded_width: expected %0d, got %0d", exp.padded_width, got.padded_width);
      errors++;
    end
    if (got.padded_height !== exp.padded_height) begin
      $error("padded_height: expected %0d, got %0d", exp.padded_height, got.padded_height);
      errors++;
    end
  endtask

  // monitor: predict on accepted input words, check accepted output words
  always @(posedge clk_i) begin
    out_word_t exp;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      in_fire <= rst_ni && in_valid && !in_stall;
      if (rst_ni && cfg_valid && cfg_ready) begin
        if (cfg_index == RegImageWidth) width_reg = cfg_data;
        else if (cfg_index == RegImageHeight) height_reg = cfg_data;
      end
      if (rst_ni && in_valid && !in_stall) begin
        if (pad_pixel(in_word, exp)) expected_pixels = {expected_pixels, exp};
      end
      if (rst_ni && out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected output word: pixel_out %0d", out_word.pixel_out);
          errors++;
        end else begin
          exp = expected_pixels.pop_front();
          check_pixel(exp, out_word);
          pixels_seen++;
          if (exp.is_padding) pads_seen++;
          if (exp.is_last) frames_done++;
        end
      end
    end
  end

  // driver: inputs move on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_fire) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          in_valid <= 1'b1;
          in_word <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready) break;
    end
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic add_word(op_e op, logic [PixW-1:0] pix);
    in_word_t w;
    w.func = op;
    w.pixel_in = pix;
    pending_words = {pending_words, w};
    words_queued++;
  endtask

  // fill: 0 random, 1 all zero, 2 all full scale
  task automatic load_image(int unsigned w, int unsigned h, int unsigned fill,
                            int unsigned noise_pct);
    logic [PixW-1:0] pix;
    for (int unsigned i = 0; i < w * h; i++) begin
      pix = (fill == 1) ? 8'd0 : (fill == 2) ? 8'd255 : PixW'($urandom);
      if ($urandom_range(99) < noise_pct) add_word(OP_PULL, PixW'($urandom));
      add_word(OP_PUSH, pix);
    end
  endtask

  task automatic pull_image(int unsigned n, int unsigned noise_pct);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) add_word(OP_PUSH, PixW'($urandom));
      add_word(OP_PULL, PixW'($urandom));
    end
  endtask

  task automatic run_frame(int unsigned w, int unsigned h, int unsigned fill,
                           int unsigned noise_pct);
    int unsigned cw, ch;
    cw = clamp_dim(w[DimW-1:0]);
    ch = clamp_dim(h[DimW-1:0]);
    write_reg(RegImageWidth, w[DimW-1:0]);
    write_reg(RegImageHeight, h[DimW-1:0]);
    load_image(cw, ch, fill, noise_pct);
    pull_image(((cw + 7) / 8) * 8 * ((ch + 7) / 8) * 8, noise_pct);
    drain();
  endtask

  // step through the idling phases
  task automatic next_pace();
    case (pace_phase % 4)
      0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
      1: begin snd_idle_pct = 86; rcv_stall_pct = 0;  end
      2: begin snd_idle_pct = 0;  rcv_stall_pct = 86; end
      default: begin snd_idle_pct = 30; rcv_stall_pct = 30; end
    endcase
    pace_phase++;
  endtask

  initial begin
    int unsigned w, h;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    clear_frame();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // aligned image at reset dimensions, no register written, then small and zero-width frames
    next_pace();
    load_image(8, 8, 2, 0);
    pull_image(64, 0);
    drain();
    next_pace();
    run_frame(1, 1, 2, 0);
    next_pace();
    run_frame(3, 2, 1, 0);
    next_pace();
    run_frame(0, 5, 0, 10);

    // shrink after loading: block averages above full scale saturate
    next_pace();
    write_reg(RegImageWidth, 9'd12);
    write_reg(RegImageHeight, 9'd12);
    load_image(12, 12, 2, 0);
    drain();
    write_reg(RegImageWidth, 9'd5);
    write_reg(RegImageHeight, 9'd3);
    pull_image(72, 0);
    drain();

    // shrink mid-pull: remaining blocks hold no real pixels
    next_pace();
    write_reg(RegImageWidth, 9'd8);
    write_reg(RegImageHeight, 9'd16);
    load_image(8, 16, 0, 0);
    pull_image(64, 0);
    drain();
    write_reg(RegImageHeight, 9'd1);
    pull_image(10, 0);
    drain();

    while (words_queued < 1050) begin
      next_pace();
      w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 20);
      h = $urandom_range(1, 12);
      run_frame(w, h, ($urandom_range(7) == 0) ? 2 : 0, ($urandom_range(3) == 0) ? 10 : 0);
    end

    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    drain();
    $display("%0d input words over %0d frames, %0d pixels checked (%0d block averages)",
             words_queued, frames_done, pixels_seen, pads_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
